// ===== hw/rtl/rvc_pkg.sv =====
package rvc_pkg;

  localparam int MEM_BYTES = 65536;
  localparam int ROWS      = MEM_BYTES / 4;
  localparam int OFF_W     = $clog2(MEM_BYTES);
  localparam int ROW_W     = $clog2(ROWS);

  localparam logic [31:0] MEM_ORIGIN   = 32'h8000_0000;
  localparam logic [31:0] START_RESET  = 32'h8000_0000;
  localparam logic [31:0] SP_TOP       = MEM_ORIGIN + 32'(MEM_BYTES);
  localparam logic [31:0] UPPER_MASK   = 32'hFFFF_F000;

  localparam logic [6:0] OPC_LUI    = 7'b011_0111;
  localparam logic [6:0] OPC_AUIPC  = 7'b001_0111;
  localparam logic [6:0] OPC_JAL    = 7'b110_1111;
  localparam logic [6:0] OPC_JALR   = 7'b110_0111;
  localparam logic [6:0] OPC_BRANCH = 7'b110_0011;
  localparam logic [6:0] OPC_LOAD   = 7'b000_0011;
  localparam logic [6:0] OPC_STORE  = 7'b010_0011;
  localparam logic [6:0] OPC_OPIMM  = 7'b001_0011;
  localparam logic [6:0] OPC_OP     = 7'b011_0011;
  localparam logic [6:0] F7_ALT     = 7'b010_0000;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_LB   = 3'd0;
  localparam logic [2:0] F3_LH   = 3'd1;
  localparam logic [2:0] F3_LW   = 3'd2;
  localparam logic [2:0] F3_LBU  = 3'd4;
  localparam logic [2:0] F3_LHU  = 3'd5;

  localparam logic [2:0] LEN_B = 3'd1;
  localparam logic [2:0] LEN_H = 3'd2;
  localparam logic [2:0] LEN_W = 3'd4;

  typedef enum logic [1:0] {
    ITEM_WRITE   = 2'd0,
    ITEM_STEP    = 2'd1,
    ITEM_RESTART = 2'd2,
    ITEM_NOP     = 2'd3
  } item_op_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_PC_ZERO = 2'd1,
    STS_BAD_OP  = 2'd2,
    STS_RANGE   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_EX,
    ST_LD,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic             re;
    logic             we;
    logic [OFF_W-1:0] off;
    logic [2:0]       len;
    logic [31:0]      wdata;
  } mem_req_t;

  typedef struct packed {
    logic       re;
    logic [4:0] ra1;
    logic [4:0] ra2;
  } rf_rd_t;

  typedef struct packed {
    logic        we;
    logic [4:0]  wa;
    logic [31:0] wd;
  } rf_wr_t;

  function automatic logic map_ok(logic [31:0] a, logic [2:0] len);
    logic [32:0] e;
    e = {1'b0, a - MEM_ORIGIN} + 33'(len);
    return (a >= MEM_ORIGIN) && (e <= 33'(MEM_BYTES));
  endfunction

  function automatic logic [OFF_W-1:0] map_off(logic [31:0] a);
    logic [31:0] d;
    d = a - MEM_ORIGIN;
    return d[OFF_W-1:0];
  endfunction

  function automatic logic [31:0] alu(logic [2:0] f3, logic [31:0] a, logic [31:0] b,
                                      logic sub, logic sra);
    logic [31:0] r;
    unique case (f3)
      F3_ADD:  r = sub ? a - b : a + b;
      F3_SLL:  r = a << b[4:0];
      F3_SLT:  r = {31'd0, $signed(a) < $signed(b)};
      F3_SLTU: r = {31'd0, a < b};
      F3_XOR:  r = a ^ b;
      F3_SR:   r = sra ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      F3_OR:   r = a | b;
      F3_AND:  r = a & b;
      default: r = a & b;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/rvc_if.sv =====
interface rvc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] address;
  logic [31:0] data;

  modport source (output valid, opcode, address, data, input ready);
  modport sink (input valid, opcode, address, data, output ready);
endinterface

interface rvc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] executed_pc;
  logic [31:0] instruction_word;
  logic [31:0] following_pc;
  logic [31:0] return_address_value;
  logic [31:0] stack_pointer_value;

  modport source (output valid, status, executed_pc, instruction_word, following_pc,
                  return_address_value, stack_pointer_value, input ready);
  modport sink (input valid, status, executed_pc, instruction_word, following_pc,
                return_address_value, stack_pointer_value, output ready);
endinterface

// ===== hw/rtl/rvc_mem.sv =====
module rvc_mem (
  input  logic               clk,
  input  rvc_pkg::mem_req_t  req,
  output logic [31:0]        rdata
);

  logic [7:0] lb [4];
  logic [1:0] rot_r;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [7:0]                ram [rvc_pkg::ROWS];
    logic [7:0]                rbyte_r;
    logic [1:0]                d;
    logic [rvc_pkg::OFF_W:0]   bidx;
    logic [rvc_pkg::ROW_W-1:0] row;
    logic                      we_l;

    assign d    = 2'(k) - req.off[1:0];
    assign bidx = {1'b0, req.off} + (rvc_pkg::OFF_W + 1)'(d);
    assign row  = bidx[rvc_pkg::OFF_W-1:2];
    assign we_l = req.we && ({1'b0, d} < req.len);

    always_ff @(posedge clk) begin
      if (we_l) begin
        ram[row] <= 8'(req.wdata >> {d, 3'b000});
      end
      if (req.re) begin
        rbyte_r <= ram[row];
      end
    end

    assign lb[k] = rbyte_r;
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rot_r <= req.off[1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rdata[8*i +: 8] = lb[2'(rot_r + 2'(i))];
    end
  end

endmodule

// ===== hw/rtl/rvc_regfile.sv =====
module rvc_regfile (
  input  logic             clk,
  input  logic             rst_n,
  input  rvc_pkg::rf_rd_t  rd,
  input  rvc_pkg::rf_wr_t  wr,
  input  logic             clr_sp,
  output logic [31:0]      rs1,
  output logic [31:0]      rs2
);

  logic [31:0] ram [32];
  logic [31:0] valid_r;
  logic [31:0] d1_r, d2_r;
  logic        v1_r, v2_r, sp1_r, sp2_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      ram[wr.wa] <= wr.wd;
    end
    if (rd.re) begin
      d1_r  <= ram[rd.ra1];
      d2_r  <= ram[rd.ra2];
      v1_r  <= valid_r[rd.ra1];
      v2_r  <= valid_r[rd.ra2];
      sp1_r <= rd.ra1 == 5'd2;
      sp2_r <= rd.ra2 == 5'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (clr_sp) begin
        valid_r[2] <= 1'b0;
      end
      if (wr.we) begin
        valid_r[wr.wa] <= 1'b1;
      end
    end
  end

  assign rs1 = v1_r ? d1_r : (sp1_r ? rvc_pkg::SP_TOP : '0);
  assign rs2 = v2_r ? d2_r : (sp2_r ? rvc_pkg::SP_TOP : '0);

endmodule

// ===== hw/rtl/rv32i_instruction_core.sv =====
// Step item: passes through fetch read, register read and execute (plus a load state for loads).
// Write, restart and no-op items go straight from start to the result hand-off.
// Items are processed one at a time: a new item starts only at the previous hand-off.
// A one-beat input buffer and an output register decouple both channels.
// Reset is synchronous active low; afterward a clearing pass zeroes all MEM_BYTES/4 (16384)
// rows of the byte memory, during which no input beat is taken.
module rv32i_instruction_core (
  input  logic        clk,
  input  logic        rst_n,
  rvc_in_if.sink      in_ch,
  rvc_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  rvc_pkg::state_t             state_r, state_nxt;
  logic [rvc_pkg::ROW_W-1:0]   clr_cnt_r;
  logic [31:0]                 start_addr_r;
  logic [31:0]                 pc_r;
  logic [31:0]                 x1_r, x2_r;
  logic                        halted_r;
  rvc_pkg::status_t            halt_reason_r;

  logic                        buf_valid_r;
  rvc_pkg::item_op_t           buf_op_r;
  logic [31:0]                 buf_addr_r, buf_data_r;

  rvc_pkg::status_t            res_status_r;
  logic [31:0]                 res_epc_r, res_word_r;

  logic                        out_valid_r;
  rvc_pkg::status_t            out_status_r;
  logic [31:0]                 out_epc_r, out_word_r, out_pc_r, out_x1_r, out_x2_r;

  rvc_pkg::mem_req_t           mem_req;
  logic [31:0]                 mem_rdata;
  rvc_pkg::rf_rd_t             rf_rd;
  rvc_pkg::rf_wr_t             rf_wr;
  logic                        rf_clr_sp;
  logic [31:0]                 rs1, rs2;

  logic                        handoff, start, fetch_go;
  rvc_pkg::status_t            start_status;

  logic [31:0]                 ins, immi, imms, immb, immj, immu, ex_addr, ex_next_pc;
  logic [6:0]                  op, f7;
  logic [2:0]                  f3, ex_len;
  logic [4:0]                  rd_idx;
  logic                        take, ex_ld, ex_st, ex_wb;
  logic [31:0]                 ex_wb_data, ld_data;
  rvc_pkg::status_t            ex_status;

  logic                        wb_en;
  logic [4:0]                  wb_addr;
  logic [31:0]                 wb_data;

  rvc_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  rvc_regfile u_rf (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd     (rf_rd),
    .wr     (rf_wr),
    .clr_sp (rf_clr_sp),
    .rs1    (rs1),
    .rs2    (rs2)
  );

  assign in_ch.ready = !buf_valid_r && (state_r != rvc_pkg::ST_CLEAR);

  assign out_ch.valid                = out_valid_r;
  assign out_ch.status               = out_status_r;
  assign out_ch.executed_pc          = out_epc_r;
  assign out_ch.instruction_word     = out_word_r;
  assign out_ch.following_pc         = out_pc_r;
  assign out_ch.return_address_value = out_x1_r;
  assign out_ch.stack_pointer_value  = out_x2_r;

  assign handoff  = (state_r == rvc_pkg::ST_RESP) && (!out_valid_r || out_ch.ready);
  assign start    = buf_valid_r && ((state_r == rvc_pkg::ST_IDLE) || handoff);
  assign fetch_go = (buf_op_r == rvc_pkg::ITEM_STEP) && !halted_r && (pc_r != '0) &&
                    rvc_pkg::map_ok(pc_r, rvc_pkg::LEN_W);

  always_comb begin
    start_status = rvc_pkg::STS_OK;
    if (buf_op_r == rvc_pkg::ITEM_WRITE) begin
      if (!rvc_pkg::map_ok(buf_addr_r, rvc_pkg::LEN_W)) begin
        start_status = rvc_pkg::STS_RANGE;
      end
    end else if (buf_op_r == rvc_pkg::ITEM_STEP) begin
      priority if (halted_r) begin
        start_status = halt_reason_r;
      end else if (pc_r == '0) begin
        start_status = rvc_pkg::STS_PC_ZERO;
      end else if (!rvc_pkg::map_ok(pc_r, rvc_pkg::LEN_W)) begin
        start_status = rvc_pkg::STS_RANGE;
      end else begin
        start_status = rvc_pkg::STS_OK;
      end
    end
  end

  // decode and execute
  assign ins    = res_word_r;
  assign op     = ins[6:0];
  assign rd_idx = ins[11:7];
  assign f3     = ins[14:12];
  assign f7     = ins[31:25];
  assign immi   = {{20{ins[31]}}, ins[31:20]};
  assign imms   = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign immb   = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign immj   = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign immu   = ins & rvc_pkg::UPPER_MASK;
  assign ex_addr = rs1 + ((op == rvc_pkg::OPC_STORE) ? imms : immi);
  assign ex_len  = (f3[1:0] == 2'd0) ? rvc_pkg::LEN_B :
                   (f3[1:0] == 2'd1) ? rvc_pkg::LEN_H : rvc_pkg::LEN_W;

  always_comb begin
    unique case (f3)
      rvc_pkg::F3_BEQ:  take = rs1 == rs2;
      rvc_pkg::F3_BNE:  take = rs1 != rs2;
      rvc_pkg::F3_BLT:  take = $signed(rs1) < $signed(rs2);
      rvc_pkg::F3_BGE:  take = $signed(rs1) >= $signed(rs2);
      rvc_pkg::F3_BLTU: take = rs1 < rs2;
      rvc_pkg::F3_BGEU: take = rs1 >= rs2;
      default:          take = 1'b0;
    endcase
  end

  always_comb begin
    ex_status  = rvc_pkg::STS_OK;
    ex_next_pc = pc_r + 32'd4;
    ex_ld      = 1'b0;
    ex_st      = 1'b0;
    ex_wb      = 1'b0;
    ex_wb_data = '0;
    unique case (op)
      rvc_pkg::OPC_LUI: begin
        ex_wb      = 1'b1;
        ex_wb_data = immu;
      end
      rvc_pkg::OPC_AUIPC: begin
        ex_wb      = 1'b1;
        ex_wb_data = pc_r + immu;
      end
      rvc_pkg::OPC_JAL: begin
        ex_wb      = 1'b1;
        ex_wb_data = pc_r + 32'd4;
        ex_next_pc = pc_r + immj;
      end
      rvc_pkg::OPC_JALR: begin
        ex_wb      = 1'b1;
        ex_wb_data = pc_r + 32'd4;
        ex_next_pc = {ex_addr[31:1], 1'b0};
      end
      rvc_pkg::OPC_BRANCH: begin
        if (f3 == rvc_pkg::F3_SLT || f3 == rvc_pkg::F3_SLTU) begin
          ex_status = rvc_pkg::STS_BAD_OP;
        end else if (take) begin
          ex_next_pc = pc_r + immb;
        end
      end
      rvc_pkg::OPC_LOAD: begin
        if (f3 == rvc_pkg::F3_SLTU || f3 == rvc_pkg::F3_OR || f3 == rvc_pkg::F3_AND) begin
          ex_status = rvc_pkg::STS_BAD_OP;
        end else if (!rvc_pkg::map_ok(ex_addr, ex_len)) begin
          ex_status = rvc_pkg::STS_RANGE;
        end else begin
          ex_ld = 1'b1;
        end
      end
      rvc_pkg::OPC_STORE: begin
        if (f3[2] || f3 == rvc_pkg::F3_SLTU) begin
          ex_status = rvc_pkg::STS_BAD_OP;
        end else if (!rvc_pkg::map_ok(ex_addr, ex_len)) begin
          ex_status = rvc_pkg::STS_RANGE;
        end else begin
          ex_st = 1'b1;
        end
      end
      rvc_pkg::OPC_OPIMM: begin
        ex_wb      = 1'b1;
        ex_wb_data = rvc_pkg::alu(f3, rs1, immi, 1'b0, ins[30]);
      end
      rvc_pkg::OPC_OP: begin
        ex_wb      = 1'b1;
        ex_wb_data = rvc_pkg::alu(f3, rs1, rs2, f7 == rvc_pkg::F7_ALT, f7 != '0);
      end
      default: ex_status = rvc_pkg::STS_BAD_OP;
    endcase
  end

  always_comb begin
    unique case (f3)
      rvc_pkg::F3_LB:  ld_data = {{24{mem_rdata[7]}}, mem_rdata[7:0]};
      rvc_pkg::F3_LH:  ld_data = {{16{mem_rdata[15]}}, mem_rdata[15:0]};
      rvc_pkg::F3_LBU: ld_data = {24'd0, mem_rdata[7:0]};
      rvc_pkg::F3_LHU: ld_data = {16'd0, mem_rdata[15:0]};
      default:         ld_data = mem_rdata;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rvc_pkg::ST_CLEAR: begin
        if (clr_cnt_r == '1) begin
          state_nxt = rvc_pkg::ST_IDLE;
        end
      end
      rvc_pkg::ST_IDLE, rvc_pkg::ST_RESP: begin
        if (start) begin
          state_nxt = fetch_go ? rvc_pkg::ST_RD : rvc_pkg::ST_RESP;
        end else if (state_r == rvc_pkg::ST_IDLE || handoff) begin
          state_nxt = rvc_pkg::ST_IDLE;
        end
      end
      rvc_pkg::ST_RD: state_nxt = rvc_pkg::ST_EX;
      rvc_pkg::ST_EX: state_nxt = ex_ld ? rvc_pkg::ST_LD : rvc_pkg::ST_RESP;
      rvc_pkg::ST_LD: state_nxt = rvc_pkg::ST_RESP;
      default:        state_nxt = rvc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    mem_req   = '0;
    rf_rd     = '0;
    rf_clr_sp = 1'b0;
    wb_en     = 1'b0;
    wb_addr   = rd_idx;
    wb_data   = ex_wb_data;
    unique case (state_r)
      rvc_pkg::ST_CLEAR: begin
        mem_req.we  = 1'b1;
        mem_req.off = {clr_cnt_r, 2'b00};
        mem_req.len = rvc_pkg::LEN_W;
      end
      rvc_pkg::ST_RD: begin
        rf_rd.re  = 1'b1;
        rf_rd.ra1 = mem_rdata[19:15];
        rf_rd.ra2 = mem_rdata[24:20];
      end
      rvc_pkg::ST_EX: begin
        mem_req.re    = ex_ld;
        mem_req.we    = ex_st;
        mem_req.off   = rvc_pkg::map_off(ex_addr);
        mem_req.len   = ex_len;
        mem_req.wdata = rs2;
        wb_en         = (ex_status == rvc_pkg::STS_OK) && ex_wb;
      end
      rvc_pkg::ST_LD: begin
        wb_en   = 1'b1;
        wb_data = ld_data;
      end
      default: begin
        mem_req = '0;
      end
    endcase
    if (start) begin
      if (buf_op_r == rvc_pkg::ITEM_WRITE) begin
        mem_req.we    = start_status == rvc_pkg::STS_OK;
        mem_req.off   = rvc_pkg::map_off(buf_addr_r);
        mem_req.len   = rvc_pkg::LEN_W;
        mem_req.wdata = buf_data_r;
      end else if (fetch_go) begin
        mem_req.re  = 1'b1;
        mem_req.off = rvc_pkg::map_off(pc_r);
        mem_req.len = rvc_pkg::LEN_W;
      end
      rf_clr_sp = buf_op_r == rvc_pkg::ITEM_RESTART;
    end
    rf_wr.we = wb_en && (wb_addr != '0);
    rf_wr.wa = wb_addr;
    rf_wr.wd = wb_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rvc_pkg::ST_CLEAR;
      clr_cnt_r     <= '0;
      start_addr_r  <= rvc_pkg::START_RESET;
      pc_r          <= rvc_pkg::START_RESET;
      x1_r          <= '0;
      x2_r          <= rvc_pkg::SP_TOP;
      halted_r      <= 1'b0;
      halt_reason_r <= rvc_pkg::STS_OK;
      buf_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == rvc_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cfg_we) begin
        start_addr_r <= cfg_wdata;
      end
      if (in_ch.valid && in_ch.ready) begin
        buf_valid_r <= 1'b1;
      end else if (start) begin
        buf_valid_r <= 1'b0;
      end
      if (handoff) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (start) begin
        if (buf_op_r == rvc_pkg::ITEM_RESTART) begin
          pc_r          <= start_addr_r;
          x2_r          <= rvc_pkg::SP_TOP;
          halted_r      <= 1'b0;
          halt_reason_r <= rvc_pkg::STS_OK;
        end else if (buf_op_r == rvc_pkg::ITEM_STEP && start_status != rvc_pkg::STS_OK) begin
          halted_r      <= 1'b1;
          halt_reason_r <= start_status;
        end
      end
      if (state_r == rvc_pkg::ST_EX) begin
        if (ex_status != rvc_pkg::STS_OK) begin
          halted_r      <= 1'b1;
          halt_reason_r <= ex_status;
        end else if (!ex_ld) begin
          pc_r <= ex_next_pc;
        end
      end
      if (state_r == rvc_pkg::ST_LD) begin
        pc_r <= pc_r + 32'd4;
      end
      if (wb_en && wb_addr == 5'd1) begin
        x1_r <= wb_data;
      end
      if (wb_en && wb_addr == 5'd2) begin
        x2_r <= wb_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      buf_op_r   <= rvc_pkg::item_op_t'(in_ch.opcode);
      buf_addr_r <= in_ch.address;
      buf_data_r <= in_ch.data;
    end
    if (start) begin
      res_status_r <= start_status;
      res_epc_r    <= (buf_op_r == rvc_pkg::ITEM_STEP) ? pc_r : '0;
      res_word_r   <= '0;
    end
    if (state_r == rvc_pkg::ST_RD) begin
      res_word_r <= mem_rdata;
    end
    if (state_r == rvc_pkg::ST_EX) begin
      res_status_r <= ex_status;
    end
    if (handoff) begin
      out_status_r <= res_status_r;
      out_epc_r    <= res_epc_r;
      out_word_r   <= res_word_r;
      out_pc_r     <= pc_r;
      out_x1_r     <= x1_r;
      out_x2_r     <= x2_r;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rvc_pkg::ST_CLEAR) |-> !in_ch.ready)
    else $error("input beat taken during memory clear");

  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_wr.we |-> (rf_wr.wa != 5'd0))
    else $error("write to x0");

  a_exec_not_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rvc_pkg::ST_EX) |-> !halted_r)
    else $error("execute while halted");

  a_handoff_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    handoff |=> out_valid_r)
    else $error("result beat lost at hand-off");
`endif

endmodule

// ===== tb/tb_rv32i_instruction_core.sv =====
module tb_rv32i_instruction_core;

  localparam int LIMIT = 600000;
  localparam int ITEMS = 1250;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] epc;
    logic [31:0] word;
    logic [31:0] next_pc;
    logic [31:0] ra;
    logic [31:0] sp;
  } core_result_t;

  class core_scoreboard;
    logic [31:0]  start_addr;
    logic [31:0]  pc;
    logic [31:0]  regs [32];
    bit [7:0]     mem [rvc_pkg::MEM_BYTES];
    bit           halted;
    logic [1:0]   reason;
    core_result_t pending_q [$];
    int           errors;
    int           steps;
    int           checked;

    function new();
      start_addr = rvc_pkg::START_RESET;
      pc = rvc_pkg::START_RESET;
      foreach (regs[i]) regs[i] = '0;
      regs[2] = rvc_pkg::SP_TOP;
      halted = 0;
      reason = rvc_pkg::STS_OK;
      errors = 0;
      steps = 0;
      checked = 0;
    endfunction

    function bit in_mem(logic [31:0] a, int len, output int off);
      logic [32:0] e;
      off = int'(32'(a - rvc_pkg::MEM_ORIGIN) & 32'h7FFF_FFFF);
      e = {1'b0, a - rvc_pkg::MEM_ORIGIN} + 33'(len);
      return (a >= rvc_pkg::MEM_ORIGIN) && (e <= 33'(rvc_pkg::MEM_BYTES));
    endfunction

    function logic [31:0] rd_mem(int off, int len);
      logic [31:0] v;
      v = '0;
      for (int i = 0; i < len; i++) v[8*i +: 8] = mem[off + i];
      return v;
    endfunction

    function void wr_mem(int off, int len, logic [31:0] v);
      for (int i = 0; i < len; i++) mem[off + i] = v[8*i +: 8];
    endfunction

    function void wr_reg(logic [4:0] r, logic [31:0] v);
      if (r != 0) regs[r] = v;
    endfunction

    function logic [31:0] calc(logic [2:0] f3, logic [31:0] a, logic [31:0] b,
                               bit sub, bit arith);
      case (f3)
        rvc_pkg::F3_ADD:  return sub ? a - b : a + b;
        rvc_pkg::F3_SLL:  return a << b[4:0];
        rvc_pkg::F3_SLT:  return {31'd0, (a ^ 32'h8000_0000) < (b ^ 32'h8000_0000)};
        rvc_pkg::F3_SLTU: return {31'd0, a < b};
        rvc_pkg::F3_XOR:  return a ^ b;
        rvc_pkg::F3_SR:   return arith ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
        rvc_pkg::F3_OR:   return a | b;
        default:          return a & b;
      endcase
    endfunction

    function logic [1:0] run_instr(logic [31:0] ins, output logic [31:0] nxt);
      logic [31:0] a, b, immi, imms, immb, immj, t;
      logic [2:0]  f3;
      logic [4:0]  rd;
      logic [6:0]  f7;
      bit          take;
      int          len, off;
      f3 = ins[14:12];
      rd = ins[11:7];
      f7 = ins[31:25];
      a = regs[ins[19:15]];
      b = regs[ins[24:20]];
      immi = {{20{ins[31]}}, ins[31:20]};
      imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
      immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
      immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
      nxt = pc + 4;
      case (ins[6:0])
        rvc_pkg::OPC_LUI: wr_reg(rd, ins & rvc_pkg::UPPER_MASK);
        rvc_pkg::OPC_AUIPC: wr_reg(rd, pc + (ins & rvc_pkg::UPPER_MASK));
        rvc_pkg::OPC_JAL: begin
          wr_reg(rd, pc + 4);
          nxt = pc + immj;
        end
        rvc_pkg::OPC_JALR: begin
          t = (a + immi) & ~32'd1;
          wr_reg(rd, pc + 4);
          nxt = t;
        end
        rvc_pkg::OPC_BRANCH: begin
          case (f3)
            rvc_pkg::F3_BEQ:  take = a == b;
            rvc_pkg::F3_BNE:  take = a != b;
            rvc_pkg::F3_BLT:  take = $signed(a) < $signed(b);
            rvc_pkg::F3_BGE:  take = $signed(a) >= $signed(b);
            rvc_pkg::F3_BLTU: take = a < b;
            rvc_pkg::F3_BGEU: take = a >= b;
            default: return rvc_pkg::STS_BAD_OP;
          endcase
          if (take) nxt = pc + immb;
        end
        rvc_pkg::OPC_LOAD: begin
          if (f3 == 3 || f3 > 5) return rvc_pkg::STS_BAD_OP;
          len = (f3[1:0] == 0) ? 1 : (f3[1:0] == 1) ? 2 : 4;
          if (!in_mem(a + immi, len, off)) return rvc_pkg::STS_RANGE;
          t = rd_mem(off, len);
          if (f3 == rvc_pkg::F3_LB) t = {{24{t[7]}}, t[7:0]};
          else if (f3 == rvc_pkg::F3_LH) t = {{16{t[15]}}, t[15:0]};
          wr_reg(rd, t);
        end
        rvc_pkg::OPC_STORE: begin
          if (f3 > 2) return rvc_pkg::STS_BAD_OP;
          len = (f3 == 0) ? 1 : (f3 == 1) ? 2 : 4;
          if (!in_mem(a + imms, len, off)) return rvc_pkg::STS_RANGE;
          wr_mem(off, len, b);
        end
        rvc_pkg::OPC_OPIMM: wr_reg(rd, calc(f3, a, immi, 0, ins[30]));
        rvc_pkg::OPC_OP: wr_reg(rd, calc(f3, a, b, f7 == rvc_pkg::F7_ALT, f7 != 0));
        default: return rvc_pkg::STS_BAD_OP;
      endcase
      return rvc_pkg::STS_OK;
    endfunction

    function void note_input(logic [1:0] op, logic [31:0] addr, logic [31:0] data);
      core_result_t r;
      logic [31:0]  nxt;
      int           off;
      r.status = rvc_pkg::STS_OK;
      r.epc = '0;
      r.word = '0;
      if (op == rvc_pkg::ITEM_WRITE) begin
        if (in_mem(addr, 4, off)) wr_mem(off, 4, data);
        else r.status = rvc_pkg::STS_RANGE;
      end else if (op == rvc_pkg::ITEM_RESTART) begin
        pc = start_addr;
        regs[2] = rvc_pkg::SP_TOP;
        halted = 0;
        reason = rvc_pkg::STS_OK;
      end else if (op == rvc_pkg::ITEM_STEP) begin
        steps++;
        r.epc = pc;
        if (halted) r.status = reason;
        else if (pc == 0) r.status = rvc_pkg::STS_PC_ZERO;
        else if (!in_mem(pc, 4, off)) r.status = rvc_pkg::STS_RANGE;
        else begin
          r.word = rd_mem(off, 4);
          r.status = run_instr(r.word, nxt);
          if (r.status == rvc_pkg::STS_OK) pc = nxt;
        end
        if (r.status != rvc_pkg::STS_OK) begin
          halted = 1;
          reason = r.status;
        end
      end
      r.next_pc = pc;
      r.ra = regs[1];
      r.sp = regs[2];
      pending_q.push_back(r);
    endfunction

    function void check_result(core_result_t got);
      core_result_t e;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.epc !== e.epc) begin
        $error("executed_pc exp %h got %h", e.epc, got.epc); errors++;
      end
      if (got.word !== e.word) begin
        $error("instruction_word exp %h got %h", e.word, got.word); errors++;
      end
      if (got.next_pc !== e.next_pc) begin
        $error("following_pc exp %h got %h", e.next_pc, got.next_pc); errors++;
      end
      if (got.ra !== e.ra) begin
        $error("return_address_value exp %h got %h", e.ra, got.ra); errors++;
      end
      if (got.sp !== e.sp) begin
        $error("stack_pointer_value exp %h got %h", e.sp, got.sp); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [31:0] cfg_wdata = '0;
  int cycles = 0;
  int sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  core_scoreboard sb = new();

  rvc_in_if in_ch ();
  rvc_out_if out_ch ();

  rv32i_instruction_core i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.opcode = '0;
    in_ch.address = '0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  always @(negedge clk) out_ch.ready = ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    core_result_t g;
    cycles++;
    if (cycles > LIMIT) begin
      $display("rv32i_instruction_core test failed");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      g.status = out_ch.status;
      g.epc = out_ch.executed_pc;
      g.word = out_ch.instruction_word;
      g.next_pc = out_ch.following_pc;
      g.ra = out_ch.return_address_value;
      g.sp = out_ch.stack_pointer_value;
      sb.check_result(g);
    end
  end

  task automatic send(logic [1:0] op, logic [31:0] addr, logic [31:0] data);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 0;
      @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.opcode = op;
    in_ch.address = addr;
    in_ch.data = data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(op, addr, data);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_start(logic [31:0] v);
    drain();
    cfg_we = 1;
    cfg_wdata = v;
    sb.start_addr = v;
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic logic [31:0] gen_instr();
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [11:0] imm;
    logic [20:0] o;
    int          k;
    rd = 5'($urandom_range(7));
    rs1 = 5'($urandom_range(7));
    rs2 = 5'($urandom_range(7));
    f3 = 3'($urandom_range(7));
    imm = 12'($urandom);
    o = 21'((int'($urandom_range(24)) - 8) * 2);
    k = $urandom_range(99);
    if (k < 6) return {20'($urandom_range(32'hFFFFF)), rd, rvc_pkg::OPC_LUI};
    if (k < 12) return {20'($urandom_range(32'hFFFFF)), rd, rvc_pkg::OPC_AUIPC};
    if (k < 17) return {o[20], o[10:1], o[11], o[19:12], rd, rvc_pkg::OPC_JAL};
    if (k < 21) return {12'(int'($urandom_range(16)) - 8), 5'd1, f3, rd, rvc_pkg::OPC_JALR};
    if (k < 30) return {o[12], o[10:5], rs2, rs1, f3, o[4:1], o[11], rvc_pkg::OPC_BRANCH};
    if (k < 52) begin
      if ($urandom_range(3) != 0) begin
        rs1 = 5'd2;
        imm = 12'(-int'($urandom_range(1, 64)));
      end
      if (k < 40) return {imm, rs1, f3, rd, rvc_pkg::OPC_LOAD};
      return {imm[11:5], rs2, rs1, f3, imm[4:0], rvc_pkg::OPC_STORE};
    end
    if (k < 72) return {imm, rs1, f3, rd, rvc_pkg::OPC_OPIMM};
    if (k < 92) begin
      k = $urandom_range(3);
      return {(k == 0) ? 7'($urandom) : (k == 1) ? rvc_pkg::F7_ALT : 7'd0,
              rs2, rs1, f3, rd, rvc_pkg::OPC_OP};
    end
    if (k < 94) return 32'h0000_0073;
    if (k < 96) return 32'h0000_000F;
    return $urandom;
  endfunction

  task automatic run_program(int n_words, int n_steps);
    logic [31:0] sa;
    sa = rvc_pkg::MEM_ORIGIN + 4 * $urandom_range(64);
    if ($urandom_range(9) == 0) sa = sa + $urandom_range(1, 3);
    set_start(sa);
    for (int i = 0; i < n_words; i++) send(rvc_pkg::ITEM_WRITE, sa + 4 * i, gen_instr());
    send(rvc_pkg::ITEM_RESTART, $urandom, $urandom);
    for (int i = 0; i < n_steps; i++) begin
      case ($urandom_range(19))
        0: send(rvc_pkg::ITEM_NOP, $urandom, $urandom);
        1: send(rvc_pkg::ITEM_WRITE, $urandom, $urandom);
        2: send(rvc_pkg::ITEM_WRITE, rvc_pkg::SP_TOP - 4 * $urandom_range(1, 16), $urandom);
        default: send(rvc_pkg::ITEM_STEP, $urandom, $urandom);
      endcase
    end
  endtask

  initial begin
    int prog;
    repeat (4) @(negedge clk);
    rst_n = 1;

    set_start(32'h0000_0000);
    send(rvc_pkg::ITEM_RESTART, '0, '0);
    send(rvc_pkg::ITEM_STEP, '0, '0);
    send(rvc_pkg::ITEM_STEP, '0, '0);
    send(rvc_pkg::ITEM_WRITE, rvc_pkg::MEM_ORIGIN, 32'hFFFF_FFFF);
    send(rvc_pkg::ITEM_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    set_start(32'hFFFF_FFFF);
    send(rvc_pkg::ITEM_RESTART, '0, '0);
    send(rvc_pkg::ITEM_STEP, '0, '0);
    send(rvc_pkg::ITEM_WRITE, rvc_pkg::SP_TOP - 3, 32'h1234_5678);
    send(rvc_pkg::ITEM_WRITE, 32'h7FFF_FFFF, 32'h1234_5678);
    set_start(rvc_pkg::SP_TOP - 4);
    send(rvc_pkg::ITEM_WRITE, rvc_pkg::SP_TOP - 4,
         {12'hFFF, 5'd0, rvc_pkg::F3_ADD, 5'd3, rvc_pkg::OPC_OPIMM});
    send(rvc_pkg::ITEM_RESTART, '0, '0);
    send(rvc_pkg::ITEM_STEP, '0, '0);
    send(rvc_pkg::ITEM_STEP, '0, '0);
    set_start(rvc_pkg::MEM_ORIGIN);
    send(rvc_pkg::ITEM_WRITE, rvc_pkg::MEM_ORIGIN, {20'h80000, 5'd1, rvc_pkg::OPC_LUI});
    send(rvc_pkg::ITEM_WRITE, rvc_pkg::MEM_ORIGIN + 4,
         {12'h404, 5'd3, rvc_pkg::F3_SR, 5'd4, rvc_pkg::OPC_OPIMM});
    send(rvc_pkg::ITEM_WRITE, rvc_pkg::MEM_ORIGIN + 8,
         {rvc_pkg::F7_ALT, 5'd3, 5'd1, rvc_pkg::F3_ADD, 5'd5, rvc_pkg::OPC_OP});
    send(rvc_pkg::ITEM_WRITE, rvc_pkg::MEM_ORIGIN + 12,
         {7'd1, 5'd4, 5'd3, rvc_pkg::F3_SR, 5'd6, rvc_pkg::OPC_OP});
    send(rvc_pkg::ITEM_WRITE, rvc_pkg::MEM_ORIGIN + 16, 32'h0000_0073);
    send(rvc_pkg::ITEM_RESTART, '0, '0);
    repeat (6) send(rvc_pkg::ITEM_STEP, '0, '0);

    prog = 0;
    while (sent < ITEMS) begin
      case (prog % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      run_program($urandom_range(6, 16), $urandom_range(10, 24));
      prog++;
    end

    drain();
    repeat (20) @(negedge clk);
    $display("%0d items sent, %0d results checked, %0d instruction steps over %0d programs",
             sent, sb.checked, sb.steps, prog);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("rv32i_instruction_core test passed");
    end else begin
      $display("rv32i_instruction_core test failed");
    end
    $finish;
  end
endmodule
